// File: design/mh_pkg.sv
// mh_pkg: shared types and constants for the magnetometer heading block.
// Holds the payload structs, the classified queue word and the arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package mh_pkg;

  localparam int AXIS_W     = 16;
  localparam int MAG_W      = 17;   // |axis| reaches 32768
  localparam int PRESHIFT   = 14;
  localparam int CXY_W      = 34;   // CORDIC x/y, signed, with gain headroom
  localparam int ANG_W      = 32;   // angle accumulator, signed
  localparam int THETA_W    = 30;   // clamped first-quadrant angle
  localparam int SUM_W      = 33;   // quadrant-corrected total plus rounding half
  localparam int FRAC_BITS  = 16;
  localparam int RND_W      = SUM_W - FRAC_BITS;
  localparam int TABLE_LEN  = 24;
  localparam int QUEUE_DEPTH = 2;

  // Angles in hundredths of a degree times 65536
  localparam logic [ANG_W-1:0] DEG90   = 32'd589824000;
  localparam logic [SUM_W-1:0] DEG180  = 33'd1179648000;
  localparam logic [SUM_W-1:0] DEG360  = 33'd2359296000;
  localparam logic [SUM_W-1:0] HALF_LSB = 33'd32768;
  localparam logic [RND_W-1:0] FULL_TURN = 17'd36000;

  typedef struct packed {
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_z;
    logic signed [AXIS_W-1:0] axis_y;
  } in_t;

  typedef struct packed {
    logic [AXIS_W-1:0]        heading;
    logic signed [AXIS_W-1:0] out_x;
    logic signed [AXIS_W-1:0] out_y;
    logic signed [AXIS_W-1:0] out_z;
  } out_t;

  // Per-sample info that rides along the angle pipeline
  typedef struct packed {
    logic zero;    // X = Y = 0
    logic x_neg;
    logic y_neg;
    in_t  axes;
  } meta_t;

  // Word moved from the front part to the back part
  typedef struct packed {
    meta_t            meta;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
  } cls_t;

  // atan(2^-i) in hundredths of a degree times 65536
  function automatic logic [ANG_W-1:0] atan_entry(input int unsigned i);
    logic [ANG_W-1:0] v;
    unique case (i)
      0:  v = 32'd294912000;
      1:  v = 32'd174096719;
      2:  v = 32'd91987925;
      3:  v = 32'd46694507;
      4:  v = 32'd23437865;
      5:  v = 32'd11730358;
      6:  v = 32'd5866610;
      7:  v = 32'd2933484;
      8:  v = 32'd1466764;
      9:  v = 32'd733384;
      10: v = 32'd366693;
      11: v = 32'd183346;
      12: v = 32'd91673;
      13: v = 32'd45837;
      14: v = 32'd22918;
      15: v = 32'd11459;
      16: v = 32'd5730;
      17: v = 32'd2865;
      18: v = 32'd1432;
      19: v = 32'd716;
      20: v = 32'd358;
      21: v = 32'd179;
      22: v = 32'd90;
      23: v = 32'd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: design/magnetometer_heading.sv
// magnetometer_heading: top level; front classifier, queue and CORDIC back end.
// Depends on mh_pkg, mh_front, mh_queue, mh_back.
`timescale 1ns / 1ps

// Compass heading from one magnetometer sample. Drive sample and raise start;
// the word is taken on a clock edge where busy is low. One sample can be taken
// every cycle: the back end is a fully unrolled CORDIC pipeline with one stage
// per iteration, and it never stalls, so busy stays low in steady use. Each
// result appears on result for one cycle with done high, after its sample has passed
// the front register, the queue, the CORDIC load register, ANGLE_ITERATIONS CORDIC
// stages, and the clamp, fix-up/round and output registers. The receiver cannot
// hold results off. heading is in hundredths of a degree, 0 to 35999, measured as
// atan2(X, Y); X = Y = 0 gives 0.

module magnetometer_heading import mh_pkg::*; #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  in_t  sample,
  output logic busy,
  output logic done,
  output out_t result
);

  logic push;
  cls_t push_word;
  logic q_full;
  logic q_empty;
  logic pop;
  cls_t head;

  mh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .sample    (sample),
    .busy      (busy),
    .push      (push),
    .push_word (push_word),
    .q_full    (q_full)
  );

  mh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  mh_back #(
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .done    (done),
    .result  (result)
  );

endmodule

// File: design/mh_front.sv
// mh_front: takes a sample word, classifies it (quadrant, magnitudes, zero)
// and hands it to the queue. Depends on mh_pkg.
`timescale 1ns / 1ps

module mh_front import mh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  in_t  sample,
  output logic busy,
  output logic push,
  output cls_t push_word,
  input  logic q_full
);

  logic f_valid;
  cls_t f_word;
  logic ready;
  logic take;

  cls_t cls_next;
  logic signed [MAG_W-1:0] sx;
  logic signed [MAG_W-1:0] sy;

  assign push  = f_valid && !q_full;
  assign ready = !f_valid || push;
  assign busy  = !ready;
  assign take  = start && ready;
  assign push_word = f_word;

  always_comb begin
    sx = {sample.axis_x[AXIS_W-1], sample.axis_x};
    sy = {sample.axis_y[AXIS_W-1], sample.axis_y};
    cls_next.meta.axes  = sample;
    cls_next.meta.x_neg = sample.axis_x[AXIS_W-1];
    cls_next.meta.y_neg = sample.axis_y[AXIS_W-1];
    cls_next.meta.zero  = (sample.axis_x == '0) && (sample.axis_y == '0);
    cls_next.mag_x = sx[MAG_W-1] ? MAG_W'(-sx) : MAG_W'(sx);
    cls_next.mag_y = sy[MAG_W-1] ? MAG_W'(-sy) : MAG_W'(sy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (ready) begin
      f_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_word <= cls_next;
    end
  end

endmodule

// File: design/mh_queue.sv
// mh_queue: short FIFO between the front and back parts.
// Flop storage, head word visible combinationally. Depends on mh_pkg.
`timescale 1ns / 1ps

module mh_queue import mh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t push_word,
  input  logic pop,
  output cls_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cls_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

// File: design/mh_back.sv
// mh_back: unrolled vectoring CORDIC, clamp, quadrant fix-up, rounding and wrap.
// Drains the queue every cycle; results leave on a one-cycle strobe. Depends on mh_pkg.
`timescale 1ns / 1ps

module mh_back import mh_pkg::*; #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  cls_t head,
  output logic pop,
  output logic done,
  output out_t result
);

  localparam int N = ANGLE_ITERATIONS;

  // CORDIC stage registers; index 0 is the loaded word
  logic                    s_valid [N+1];
  meta_t                   s_meta  [N+1];
  logic signed [CXY_W-1:0] cx      [N+1];
  logic signed [CXY_W-1:0] cy      [N+1];
  logic signed [ANG_W-1:0] cz      [N+1];

  // clamp stage
  logic               c_valid;
  meta_t              c_meta;
  logic [THETA_W-1:0] c_theta;

  // fix-up and rounding stage
  logic             r_valid;
  meta_t            r_meta;
  logic [RND_W-1:0] r_round;

  logic [THETA_W-1:0] theta_next;
  logic [SUM_W-1:0]   sum_next;
  logic [RND_W-1:0]   wrapped;

  assign pop = !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid[0] <= 1'b0;
    end else begin
      s_valid[0] <= pop;
    end
  end

  always_ff @(posedge clk) begin
    s_meta[0] <= head.meta;
    cx[0] <= $signed({{(CXY_W-MAG_W-PRESHIFT){1'b0}}, head.mag_y, {PRESHIFT{1'b0}}});
    cy[0] <= $signed({{(CXY_W-MAG_W-PRESHIFT){1'b0}}, head.mag_x, {PRESHIFT{1'b0}}});
    cz[0] <= '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [ANG_W-1:0] STEP = $signed(atan_entry(i));
    logic signed [CXY_W-1:0] xs;
    logic signed [CXY_W-1:0] ys;

    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        s_valid[i+1] <= 1'b0;
      end else begin
        s_valid[i+1] <= s_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      s_meta[i+1] <= s_meta[i];
      if (!cy[i][CXY_W-1]) begin
        cx[i+1] <= cx[i] + ys;
        cy[i+1] <= cy[i] - xs;
        cz[i+1] <= cz[i] + STEP;
      end else begin
        cx[i+1] <= cx[i] - ys;
        cy[i+1] <= cy[i] + xs;
        cz[i+1] <= cz[i] - STEP;
      end
    end
  end

  // clamp to [0, 90 deg]
  always_comb begin
    if (cz[N][ANG_W-1]) begin
      theta_next = '0;
    end else if ($unsigned(cz[N]) > DEG90) begin
      theta_next = THETA_W'(DEG90);
    end else begin
      theta_next = cz[N][THETA_W-1:0];
    end
  end

  // quadrant fix-up with the rounding half folded in
  always_comb begin
    unique case ({c_meta.x_neg, c_meta.y_neg})
      2'b00:   sum_next = HALF_LSB + SUM_W'(c_theta);
      2'b01:   sum_next = DEG180 + HALF_LSB - SUM_W'(c_theta);
      2'b11:   sum_next = DEG180 + HALF_LSB + SUM_W'(c_theta);
      default: sum_next = DEG360 + HALF_LSB - SUM_W'(c_theta);
    endcase
  end

  assign wrapped = (r_round >= FULL_TURN) ? r_round - FULL_TURN : r_round;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      r_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      c_valid <= s_valid[N];
      r_valid <= c_valid;
      done    <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_meta  <= s_meta[N];
    c_theta <= theta_next;
    r_meta  <= c_meta;
    r_round <= sum_next[SUM_W-1:FRAC_BITS];
    result.heading <= r_meta.zero ? '0 : AXIS_W'(wrapped);
    result.out_x   <= r_meta.axes.axis_x;
    result.out_y   <= r_meta.axes.axis_y;
    result.out_z   <= r_meta.axes.axis_z;
  end

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.heading < AXIS_W'(36000)))
    else $error("heading out of range");

  a_zero_heading: assert property (@(posedge clk) disable iff (rst)
    done && (result.out_x == '0) && (result.out_y == '0) |-> (result.heading == '0))
    else $error("zero vector gave nonzero heading");

  a_x_positive: assert property (@(posedge clk) disable iff (rst)
    s_valid[N] |-> !cx[N][CXY_W-1])
    else $error("CORDIC x went negative");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    c_valid |=> r_valid)
    else $error("result lost between clamp and rounding");

endmodule

// File: tb/sv/magnetometer_heading_test.sv
// magnetometer_heading_test: self-checking bench for the compass heading block.
// Random and directed axis words against an in-bench CORDIC heading predictor.
// Depends on mh_pkg and magnetometer_heading.
`timescale 1ns / 1ps

module magnetometer_heading_test;
  import mh_pkg::*;

  localparam int ITERS       = 16;
  localparam int RAND_WORDS  = 1800;
  localparam int SETTLE_CYC  = ITERS + 30;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ARC_LEN     = 24;
  localparam longint QTR_TURN  = 64'sd9000 * 65536;
  localparam longint HALF_TURN = 64'sd18000 * 65536;
  localparam longint FULL_TURN_FX = 64'sd36000 * 65536;

  // Random axis value shapes
  typedef enum int {AX_ANY, AX_TINY, AX_EDGE, AX_ZERO} axis_kind_t;

  logic clk;
  logic rst;
  logic start = 1'b0;
  in_t  sample = '0;
  logic busy;
  logic done;
  out_t result;

  in_t  pend_q[$];
  out_t heading_due_q[$];
  int   gap_left = 0;
  bit   burst_mode = 1'b0;
  int   mismatch_cnt = 0;
  int   cycle_cnt = 0;

  // atan(2^-i), hundredths of a degree scaled by 2^16
  longint arc_tab [ARC_LEN] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733384, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45
  };

  magnetometer_heading #(.ANGLE_ITERATIONS(ITERS)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .sample (sample),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Vectoring CORDIC on |Y|, |X|, then quadrant fix-up and round half up
  function automatic out_t compass_heading(in_t s);
    longint ax, ay, cx, cy, ang, xs, ys, total, hd;
    out_t r;
    ax = longint'($signed(s.axis_x));
    ay = longint'($signed(s.axis_y));
    hd = 0;
    if (ax != 0 || ay != 0) begin
      cx = (ay < 0 ? -ay : ay) <<< 14;
      cy = (ax < 0 ? -ax : ax) <<< 14;
      ang = 0;
      for (int i = 0; i < ITERS && i < ARC_LEN; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (cy >= 0) begin
          cx += ys;
          cy -= xs;
          ang += arc_tab[i];
        end else begin
          cx -= ys;
          cy += xs;
          ang -= arc_tab[i];
        end
      end
      if (ang < 0) ang = 0;
      if (ang > QTR_TURN) ang = QTR_TURN;
      if (ax >= 0) total = (ay >= 0) ? ang : HALF_TURN - ang;
      else total = (ay < 0) ? HALF_TURN + ang : FULL_TURN_FX - ang;
      hd = (total + 32768) >>> 16;
      if (hd >= 36000) hd -= 36000;
    end
    r.heading = hd[15:0];
    r.out_x   = s.axis_x;
    r.out_y   = s.axis_y;
    r.out_z   = s.axis_z;
    return r;
  endfunction

  function automatic logic signed [15:0] pick_axis(axis_kind_t k);
    logic signed [15:0] v;
    case (k)
      AX_TINY: v = 16'(int'($urandom_range(0, 128)) - 64);
      AX_EDGE: begin
        case ($urandom_range(0, 5))
          0: v = -16'sd32768;
          1: v = -16'sd32767;
          2: v = 16'sd32767;
          3: v = 16'sd1;
          4: v = -16'sd1;
          default: v = 16'sd0;
        endcase
      end
      AX_ZERO: v = '0;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_cnt++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic push_word(int x, int z, int y);
    in_t s;
    s.axis_x = 16'(x);
    s.axis_z = 16'(z);
    s.axis_y = 16'(y);
    pend_q.push_back(s);
  endtask

  // Driver: one word per start; a gap is drawn whenever start drops, bursts of back-to-back words.
  // The wait lasts beyond the drawn count, since dropping start takes idle time of its own.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      heading_due_q.push_back(compass_heading(sample));
      if ($urandom_range(0, 39) == 0) burst_mode = ~burst_mode;
      if (pend_q.size() > 0 && (burst_mode || $urandom_range(0, 12) == 0)) begin
        sample <= pend_q.pop_front();
      end else begin
        start <= 1'b0;
        gap_left <= burst_mode ? 0 : $urandom_range(0, 11);
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pend_q.size() > 0) begin
        sample <= pend_q.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Monitor: results cannot be held off, take each one on the cycle it shows
  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      if (heading_due_q.size() == 0) begin
        report_mismatch("unexpected result word, heading", int'(result.heading), -1);
      end else begin
        want = heading_due_q.pop_front();
        if (result.heading !== want.heading)
          report_mismatch("heading", int'(result.heading), int'(want.heading));
        if (result.out_x !== want.out_x)
          report_mismatch("out_x", int'(result.out_x), int'(want.out_x));
        if (result.out_y !== want.out_y)
          report_mismatch("out_y", int'(result.out_y), int'(want.out_y));
        if (result.out_z !== want.out_z)
          report_mismatch("out_z", int'(result.out_z), int'(want.out_z));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[magnetometer_heading] ERROR");
      $finish;
    end
  end

  initial begin
    axis_kind_t kx, ky;
    int zx;
    rst = 1'b1;

    // Directed: origin, axes, diagonals, extremes, wrap to zero, Z extremes
    push_word(0, 0, 0);
    push_word(0, 32767, 0);
    push_word(0, -32768, 0);
    push_word(0, 0, 32767);
    push_word(0, 0, -32768);
    push_word(32767, 0, 0);
    push_word(-32768, 0, 0);
    push_word(1000, 0, 1000);
    push_word(1000, 0, -1000);
    push_word(-1000, 0, -1000);
    push_word(-1000, 0, 1000);
    push_word(-32768, 5, -32768);
    push_word(32767, -5, -32768);
    push_word(-32768, 0, 32767);
    push_word(32767, 0, 32767);
    push_word(-1, 0, 32767);      // just short of a full turn, rounds to 0
    push_word(-1, 0, -32768);
    push_word(1, 0, -32768);
    push_word(1, 0, 32767);
    push_word(-1, 0, 0);
    push_word(0, 0, -1);
    push_word(1, 0, 1);
    push_word(-16'sh5555, 16'sh5555, -16'sh2AAB);
    push_word(16'sh2AAA, -16'sh5556, 16'sh7FFF);

    for (int n = 0; n < RAND_WORDS; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin kx = AX_ANY;  ky = AX_ANY;  end
        5:             begin kx = AX_TINY; ky = AX_TINY; end
        6:             begin kx = AX_TINY; ky = AX_ANY;  end
        7:             begin kx = AX_ANY;  ky = AX_TINY; end
        8:             begin kx = AX_EDGE; ky = AX_EDGE; end
        default: begin
          kx = $urandom_range(0, 1) ? AX_ZERO : AX_EDGE;
          ky = $urandom_range(0, 1) ? AX_ANY : AX_ZERO;
        end
      endcase
      zx = $urandom_range(0, 7) == 0 ? int'(pick_axis(AX_EDGE)) : int'(pick_axis(AX_ANY));
      if ($urandom_range(0, 1)) push_word(pick_axis(kx), zx, pick_axis(ky));
      else push_word(pick_axis(ky), zx, pick_axis(kx));
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pend_q.size() != 0 || start || heading_due_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);

    if (mismatch_cnt == 0 && heading_due_q.size() == 0) begin
      $display("[magnetometer_heading] OK");
    end else begin
      $display("[magnetometer_heading] ERROR");
    end
    $finish;
  end

endmodule
